// ===== rtl/pea_pkg.sv =====
// ----------------------------------------------------------------------------
// pea_pkg
// Shared widths, constants, command codes and the exp2 root table for the
// participation entropy accumulator.
// ----------------------------------------------------------------------------
package pea_pkg;

  localparam int AMP_W    = 24;
  localparam int P_W      = 2 * AMP_W - 1;
  localparam int P_FRAC   = 2 * (AMP_W - 1);
  localparam int PSHIFT   = P_FRAC - 32;
  localparam int LFRAC    = 24;
  localparam int NORM_W   = 48;
  localparam int EXP_W    = 6;
  localparam int L_W      = EXP_W + LFRAC;
  localparam int PSUM_W   = 48;
  localparam int ESUM_W   = 40;
  localparam int ENT_W    = 24;
  localparam int TALLY_W  = 13;
  localparam int Q_W      = 16;
  localparam int MAX_VECTORS = 4096;
  localparam int TERM_W   = 39;
  localparam int ENTQ_W   = 34;
  localparam int T_W      = 34;
  localparam int TINT_W   = T_W - LFRAC;
  localparam int R_W      = 33;
  localparam int V_W      = 31;
  localparam int CNT_W    = 5;
  localparam int DIV_NW   = 41;
  localparam int DIV_DW   = 16;
  localparam int DIV_CW   = $clog2(DIV_NW + 1);

  localparam logic [Q_W-1:0]    Q_ONE    = 16'd4096;
  localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
  localparam logic [L_W-1:0]    NL_BASE  = L_W'(P_FRAC * (2 ** LFRAC));
  localparam logic [L_W-1:0]    LN_BASE  = L_W'(32 * (2 ** LFRAC));
  localparam logic [ENT_W-1:0]  ENT_MAX  = '1;
  localparam logic [PSUM_W-1:0] PSUM_MAX = '1;
  localparam logic [ESUM_W-1:0] ESUM_MAX = '1;

  // Datapath commands
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_NORM_P     = 5'd2;
  localparam logic [4:0] OP_NORM_S     = 5'd3;
  localparam logic [4:0] OP_SHIFT      = 5'd4;
  localparam logic [4:0] OP_LOG_INIT   = 5'd5;
  localparam logic [4:0] OP_LOG_STEP   = 5'd6;
  localparam logic [4:0] OP_LN_P       = 5'd7;
  localparam logic [4:0] OP_LN_S       = 5'd8;
  localparam logic [4:0] OP_QMUL       = 5'd9;
  localparam logic [4:0] OP_SHAN       = 5'd10;
  localparam logic [4:0] OP_EXP_STEP   = 5'd11;
  localparam logic [4:0] OP_EXP_FIN    = 5'd12;
  localparam logic [4:0] OP_ACC        = 5'd13;
  localparam logic [4:0] OP_ENT_SIMPLE = 5'd14;
  localparam logic [4:0] OP_DIV_ENT    = 5'd15;
  localparam logic [4:0] OP_ENT_ZERO   = 5'd16;
  localparam logic [4:0] OP_ENT_TAKE   = 5'd17;
  localparam logic [4:0] OP_VEC_DONE   = 5'd18;
  localparam logic [4:0] OP_MEAN_START = 5'd19;
  localparam logic [4:0] OP_EMIT       = 5'd20;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic p_zero;
    logic norm_done;
    logic log_last;
    logic exp_last;
    logic div_busy;
    logic q_one;
    logic s_zero;
    logic sign_ok;
    logic vec_end;
    logic band_end;
    logic out_free;
  } status_t;

  typedef logic [31:0] rom_t [0:LFRAC];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry k holds 2^(-2^-k) in Q0.32
  function automatic rom_t build_exp_rom();
    rom_t rom;
    rom[0] = 32'h8000_0000;
    for (int k = 1; k <= LFRAC; k++) begin
      rom[k] = 32'(isqrt64({rom[k-1], 32'h0}));
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== rtl/participation_entropy_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// participation_entropy_accumulator_core
// Fixed-point Renyi participation entropy, averaged over a band of vectors.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | in_valid_i / in_ready_o   | amplitude_i, vector_end_i, band_end_i
//  out      | out_valid_o / out_ready_i | mean_entropy_o, vectors_counted_o,
//           |                           | saturated_o
//  cfg      | cfg_we_i (no wait)        | cfg_wdata_i (order q, Q4.12)
//
// A zero-power component skips the arithmetic. A nonzero one runs a
// normalize shift and the 24-step log2 squaring loop, then either the ln
// multiply (q = 1) or the 24-step exp2 root-table loop. A vector end adds
// a simple entropy step when q = 1 or the sum is zero, else a second log2
// of the power sum and, if the sign is right, a divide. A band end adds
// the mean divide.
// The next request is taken as soon as the sequencer returns to idle, while
// a finished result still waits in the output register; a new band result
// holds in the sequencer until that register drains. Reset clears all sums
// and sets q to 1.
// ----------------------------------------------------------------------------
module participation_entropy_accumulator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pea_pkg::Q_W-1:0]           cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [pea_pkg::AMP_W-1:0]  amplitude_i,
  input  logic                              vector_end_i,
  input  logic                              band_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pea_pkg::ENT_W-1:0]         mean_entropy_o,
  output logic [pea_pkg::TALLY_W-1:0]       vectors_counted_o,
  output logic                              saturated_o
);

  pea_pkg::cmd_t    cmd;
  pea_pkg::status_t status;

  // Sequencer: one request at a time
  pea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic, accumulators and the result register
  pea_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .amplitude_i       (amplitude_i),
    .vector_end_i      (vector_end_i),
    .band_end_i        (band_end_i),
    .out_ready_i       (out_ready_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .mean_entropy_o    (mean_entropy_o),
    .vectors_counted_o (vectors_counted_o),
    .saturated_o       (saturated_o)
  );

  // No datapath command issues while the divider runs
  a_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> cmd.op == pea_pkg::OP_NONE)
    else $error("command issued during divide");

  // A band result loads only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == pea_pkg::OP_EMIT |-> (!out_valid_o || out_ready_i))
    else $error("result overwrote pending output");

  // Idle sequencer never leaves the divider running
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status.div_busy)
    else $error("divider busy while idle");

  // Every emitted band averages at least one vector
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vectors_counted_o != '0)
    else $error("empty band emitted");

endmodule

// ===== rtl/pea_div.sv =====
// ----------------------------------------------------------------------------
// pea_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pea_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pea_pkg::DIV_NW-1:0] num_i,
  input  logic [pea_pkg::DIV_DW-1:0] den_i,
  output logic                       busy_o,
  output logic [pea_pkg::DIV_NW-1:0] quo_o
);

  logic [pea_pkg::DIV_DW-1:0] rem_q;
  logic [pea_pkg::DIV_DW-1:0] den_q;
  logic [pea_pkg::DIV_NW-1:0] quo_q;
  logic [pea_pkg::DIV_CW-1:0] cnt_q;
  logic                       busy_q;
  logic [pea_pkg::DIV_DW:0]   sh;
  logic                       ge;

  assign sh = {rem_q, quo_q[pea_pkg::DIV_NW-1]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= pea_pkg::DIV_CW'(pea_pkg::DIV_NW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != pea_pkg::DIV_CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? pea_pkg::DIV_DW'(sh - {1'b0, den_q}) : sh[pea_pkg::DIV_DW-1:0];
      quo_q <= {quo_q[pea_pkg::DIV_NW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/pea_datapath.sv =====
// ----------------------------------------------------------------------------
// pea_datapath
// Log2/exp2 units, accumulators, divider and result register.
// ----------------------------------------------------------------------------
module pea_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pea_pkg::Q_W-1:0]           cfg_wdata_i,
  input  logic signed [pea_pkg::AMP_W-1:0]  amplitude_i,
  input  logic                              vector_end_i,
  input  logic                              band_end_i,
  input  logic                              out_ready_i,
  input  pea_pkg::cmd_t                     cmd_i,
  output pea_pkg::status_t                  status_o,
  output logic                              out_valid_o,
  output logic [pea_pkg::ENT_W-1:0]         mean_entropy_o,
  output logic [pea_pkg::TALLY_W-1:0]       vectors_counted_o,
  output logic                              saturated_o
);

  // Configuration and accumulators
  logic [pea_pkg::Q_W-1:0]     q_exp_q;
  logic [pea_pkg::PSUM_W-1:0]  psum_q;
  logic [pea_pkg::ESUM_W-1:0]  esum_q;
  logic [pea_pkg::TALLY_W-1:0] tally_q;
  logic                        clip_q;
  logic                        out_valid_q;

  // Working registers
  logic [pea_pkg::P_W-1:0]     p_q;
  logic                        vend_q;
  logic                        bend_q;
  logic [pea_pkg::NORM_W-1:0]  norm_q;
  logic [pea_pkg::EXP_W-1:0]   e_q;
  logic [pea_pkg::V_W-1:0]     v_q;
  logic [pea_pkg::LFRAC-1:0]   fr_q;
  logic [pea_pkg::CNT_W-1:0]   cnt_q;
  logic [pea_pkg::L_W-1:0]     ln_q;
  logic [pea_pkg::TINT_W-1:0]  tint_q;
  logic [pea_pkg::LFRAC-1:0]   frac_q;
  logic [pea_pkg::R_W-1:0]     r_q;
  logic [pea_pkg::TERM_W-1:0]  term_q;
  logic [pea_pkg::ENTQ_W-1:0]  ent_q;
  logic [pea_pkg::ENT_W-1:0]   mean_q;
  logic [pea_pkg::TALLY_W-1:0] cnt_out_q;
  logic                        sat_out_q;

  logic [pea_pkg::AMP_W-1:0]       amp_u;
  logic [pea_pkg::AMP_W-1:0]       mag;
  logic [2*pea_pkg::AMP_W-1:0]     p_full;
  logic [pea_pkg::Q_W-1:0]         q_eff;
  logic                            q_one;
  logic                            q_big;
  logic [pea_pkg::L_W-1:0]         l_val;
  logic [pea_pkg::L_W-1:0]         nl;
  logic                            lnpos;
  logic [pea_pkg::L_W-1:0]         lmag;
  logic [pea_pkg::L_W-1:0]         ln_src;
  logic [pea_pkg::L_W+31:0]        ln_prod;
  logic [pea_pkg::L_W+pea_pkg::Q_W-1:0] qm_prod;
  logic [pea_pkg::R_W-1:0]         pq;
  logic [pea_pkg::R_W+pea_pkg::L_W-1:0] sh_prod;
  logic [pea_pkg::R_W+31:0]        ex_prod;
  logic [2*pea_pkg::V_W-1:0]       sq;
  logic [31:0]                     sq_sh;
  logic [pea_pkg::PSUM_W:0]        acc_sum;
  logic                            ent_clip;
  logic [pea_pkg::ENT_W-1:0]       entc;
  logic [pea_pkg::ESUM_W:0]        esum_sum;
  logic                            tally_full;
  logic [pea_pkg::DIV_DW-1:0]      q_dist;
  logic                            div_start;
  logic [pea_pkg::DIV_NW-1:0]      div_num;
  logic [pea_pkg::DIV_DW-1:0]      div_den;
  logic                            div_busy;
  logic [pea_pkg::DIV_NW-1:0]      div_quo;
  logic                            mean_clip;
  logic                            out_free;

  assign amp_u  = amplitude_i;
  assign mag    = amp_u[pea_pkg::AMP_W-1] ? pea_pkg::AMP_W'(~amp_u + 1'b1) : amp_u;
  assign p_full = mag * mag;

  assign q_eff  = (q_exp_q == '0) ? pea_pkg::Q_W'(1) : q_exp_q;
  assign q_one  = q_eff == pea_pkg::Q_ONE;
  assign q_big  = q_eff > pea_pkg::Q_ONE;
  assign q_dist = q_big ? (q_eff - pea_pkg::Q_ONE) : (pea_pkg::Q_ONE - q_eff);

  assign l_val  = {e_q, fr_q};
  assign nl     = pea_pkg::NL_BASE - l_val;
  assign lnpos  = l_val >= pea_pkg::LN_BASE;
  assign lmag   = lnpos ? (l_val - pea_pkg::LN_BASE) : (pea_pkg::LN_BASE - l_val);
  assign ln_src = (cmd_i.op == pea_pkg::OP_LN_S) ? lmag : nl;
  assign ln_prod = ln_src * pea_pkg::LN2_Q32;
  assign qm_prod = nl * q_eff;

  assign pq      = p_q[pea_pkg::P_W-1:pea_pkg::PSHIFT];
  assign sh_prod = pq * ln_q;
  assign ex_prod = r_q * pea_pkg::EXP_ROM[cnt_q];
  assign sq      = v_q * v_q;
  assign sq_sh   = sq[2*pea_pkg::V_W-1:30];

  assign acc_sum    = psum_q + term_q;
  assign ent_clip   = ent_q > pea_pkg::ENTQ_W'(pea_pkg::ENT_MAX);
  assign entc       = ent_clip ? pea_pkg::ENT_MAX : ent_q[pea_pkg::ENT_W-1:0];
  assign esum_sum   = esum_q + entc;
  assign tally_full = tally_q >= pea_pkg::TALLY_W'(pea_pkg::MAX_VECTORS);
  assign mean_clip  = div_quo > pea_pkg::DIV_NW'(pea_pkg::ENT_MAX);
  assign out_free   = !out_valid_q || out_ready_i;

  // Divider operands: entropy quotient or band mean
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd_i.op)
      pea_pkg::OP_DIV_ENT: begin
        div_start = 1'b1;
        div_num   = pea_pkg::DIV_NW'({ln_q, 4'b0});
        div_den   = q_dist;
      end
      pea_pkg::OP_MEAN_START: begin
        div_start = 1'b1;
        div_num   = pea_pkg::DIV_NW'(esum_q) + pea_pkg::DIV_NW'(tally_q >> 1);
        div_den   = pea_pkg::DIV_DW'(tally_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pea_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_exp_q     <= pea_pkg::Q_ONE;
      psum_q      <= '0;
      esum_q      <= '0;
      tally_q     <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        q_exp_q <= cfg_wdata_i;
      end
      if (cmd_i.op == pea_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        pea_pkg::OP_ACC: begin
          if (acc_sum[pea_pkg::PSUM_W]) begin
            psum_q <= pea_pkg::PSUM_MAX;
            clip_q <= 1'b1;
          end else begin
            psum_q <= acc_sum[pea_pkg::PSUM_W-1:0];
          end
        end
        pea_pkg::OP_VEC_DONE: begin
          psum_q <= '0;
          if (!tally_full) begin
            tally_q <= tally_q + 1'b1;
            esum_q  <= esum_sum[pea_pkg::ESUM_W] ? pea_pkg::ESUM_MAX
                                                 : esum_sum[pea_pkg::ESUM_W-1:0];
          end
          // Flag a dropped vector, a clipped entropy or a clipped band sum
          if (tally_full || ent_clip || esum_sum[pea_pkg::ESUM_W]) begin
            clip_q <= 1'b1;
          end
        end
        pea_pkg::OP_EMIT: begin
          esum_q  <= '0;
          tally_q <= '0;
          clip_q  <= 1'b0;
        end
        default: begin
          psum_q <= psum_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pea_pkg::OP_LOAD: begin
        p_q    <= p_full[pea_pkg::P_W-1:0];
        vend_q <= vector_end_i;
        bend_q <= band_end_i;
      end
      pea_pkg::OP_NORM_P: begin
        norm_q <= pea_pkg::NORM_W'(p_q);
        e_q    <= pea_pkg::EXP_W'(pea_pkg::NORM_W - 1);
      end
      pea_pkg::OP_NORM_S: begin
        norm_q <= psum_q;
        e_q    <= pea_pkg::EXP_W'(pea_pkg::NORM_W - 1);
      end
      pea_pkg::OP_SHIFT: begin
        if (norm_q[pea_pkg::NORM_W-1 -: 16] == '0) begin
          norm_q <= norm_q << 16;
          e_q    <= e_q - pea_pkg::EXP_W'(16);
        end else if (norm_q[pea_pkg::NORM_W-1 -: 4] == '0) begin
          norm_q <= norm_q << 4;
          e_q    <= e_q - pea_pkg::EXP_W'(4);
        end else begin
          norm_q <= norm_q << 1;
          e_q    <= e_q - 1'b1;
        end
      end
      pea_pkg::OP_LOG_INIT: begin
        v_q   <= norm_q[pea_pkg::NORM_W-1 -: pea_pkg::V_W];
        fr_q  <= '0;
        cnt_q <= '0;
      end
      pea_pkg::OP_LOG_STEP: begin
        v_q   <= sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
        fr_q  <= {fr_q[pea_pkg::LFRAC-2:0], sq_sh[31]};
        cnt_q <= cnt_q + 1'b1;
      end
      pea_pkg::OP_LN_P, pea_pkg::OP_LN_S: begin
        ln_q <= ln_prod[pea_pkg::L_W+31:32];
      end
      pea_pkg::OP_QMUL: begin
        tint_q <= qm_prod[pea_pkg::L_W+pea_pkg::Q_W-1:12+pea_pkg::LFRAC];
        frac_q <= qm_prod[12+pea_pkg::LFRAC-1:12];
        r_q    <= pea_pkg::R_W'(1) << 32;
        cnt_q  <= pea_pkg::CNT_W'(1);
      end
      pea_pkg::OP_EXP_STEP: begin
        if (frac_q[pea_pkg::LFRAC-1]) begin
          r_q <= ex_prod[pea_pkg::R_W+31:32];
        end
        frac_q <= frac_q << 1;
        cnt_q  <= cnt_q + 1'b1;
      end
      pea_pkg::OP_EXP_FIN: begin
        if (tint_q > pea_pkg::TINT_W'(32)) begin
          term_q <= '0;
        end else begin
          term_q <= pea_pkg::TERM_W'(r_q >> tint_q[5:0]);
        end
      end
      pea_pkg::OP_SHAN: begin
        term_q <= sh_prod[pea_pkg::R_W+pea_pkg::L_W-1:pea_pkg::LFRAC];
      end
      pea_pkg::OP_ENT_SIMPLE: begin
        if (q_one) begin
          ent_q <= pea_pkg::ENTQ_W'(psum_q >> 16);
        end else if (q_big) begin
          ent_q <= pea_pkg::ENTQ_W'(pea_pkg::ENT_MAX) + 1'b1;
        end else begin
          ent_q <= '0;
        end
      end
      pea_pkg::OP_ENT_ZERO: begin
        ent_q <= '0;
      end
      pea_pkg::OP_ENT_TAKE: begin
        ent_q <= div_quo[pea_pkg::ENTQ_W-1:0];
      end
      pea_pkg::OP_EMIT: begin
        mean_q    <= mean_clip ? pea_pkg::ENT_MAX : div_quo[pea_pkg::ENT_W-1:0];
        cnt_out_q <= tally_q;
        sat_out_q <= clip_q | mean_clip;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign status_o.p_zero    = p_q == '0;
  assign status_o.norm_done = norm_q[pea_pkg::NORM_W-1];
  assign status_o.log_last  = cnt_q == pea_pkg::CNT_W'(pea_pkg::LFRAC - 1);
  assign status_o.exp_last  = cnt_q == pea_pkg::CNT_W'(pea_pkg::LFRAC);
  assign status_o.div_busy  = div_busy;
  assign status_o.q_one     = q_one;
  assign status_o.s_zero    = psum_q == '0;
  assign status_o.sign_ok   = lnpos != q_big;
  assign status_o.vec_end   = vend_q | bend_q;
  assign status_o.band_end  = bend_q;
  assign status_o.out_free  = out_free;

  assign out_valid_o       = out_valid_q;
  assign mean_entropy_o    = mean_q;
  assign vectors_counted_o = cnt_out_q;
  assign saturated_o       = sat_out_q;

endmodule

// ===== rtl/pea_ctrl.sv =====
// ----------------------------------------------------------------------------
// pea_ctrl
// Sequencer: steps the datapath through log2, exp2, entropy and mean.
// ----------------------------------------------------------------------------
module pea_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pea_pkg::status_t status_i,
  output pea_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PCHK   = 5'd1;
  localparam logic [4:0] S_NORM   = 5'd2;
  localparam logic [4:0] S_LOG    = 5'd3;
  localparam logic [4:0] S_LN     = 5'd4;
  localparam logic [4:0] S_QMUL   = 5'd5;
  localparam logic [4:0] S_SHAN   = 5'd6;
  localparam logic [4:0] S_EXP    = 5'd7;
  localparam logic [4:0] S_EXPF   = 5'd8;
  localparam logic [4:0] S_ACC    = 5'd9;
  localparam logic [4:0] S_VEC    = 5'd10;
  localparam logic [4:0] S_DIVE   = 5'd11;
  localparam logic [4:0] S_DIVW   = 5'd12;
  localparam logic [4:0] S_VDONE  = 5'd13;
  localparam logic [4:0] S_MSTART = 5'd14;
  localparam logic [4:0] S_MWAIT  = 5'd15;
  localparam logic [4:0] S_EMIT   = 5'd16;

  logic [4:0] state_q, state_d;
  logic       phase_q, phase_d;   // 0: component power, 1: vector sum

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o.op   = pea_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = pea_pkg::OP_LOAD;
          state_d  = S_PCHK;
        end
      end
      S_PCHK: begin
        if (status_i.p_zero) begin
          state_d = status_i.vec_end ? S_VEC : S_IDLE;
        end else begin
          cmd_o.op = pea_pkg::OP_NORM_P;
          phase_d  = 1'b0;
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        if (status_i.norm_done) begin
          cmd_o.op = pea_pkg::OP_LOG_INIT;
          state_d  = S_LOG;
        end else begin
          cmd_o.op = pea_pkg::OP_SHIFT;
        end
      end
      S_LOG: begin
        cmd_o.op = pea_pkg::OP_LOG_STEP;
        if (status_i.log_last) begin
          state_d = (!phase_q && !status_i.q_one) ? S_QMUL : S_LN;
        end
      end
      S_LN: begin
        cmd_o.op = phase_q ? pea_pkg::OP_LN_S : pea_pkg::OP_LN_P;
        state_d  = phase_q ? S_DIVE : S_SHAN;
      end
      S_SHAN: begin
        cmd_o.op = pea_pkg::OP_SHAN;
        state_d  = S_ACC;
      end
      S_QMUL: begin
        cmd_o.op = pea_pkg::OP_QMUL;
        state_d  = S_EXP;
      end
      S_EXP: begin
        cmd_o.op = pea_pkg::OP_EXP_STEP;
        if (status_i.exp_last) begin
          state_d = S_EXPF;
        end
      end
      S_EXPF: begin
        cmd_o.op = pea_pkg::OP_EXP_FIN;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = pea_pkg::OP_ACC;
        state_d  = status_i.vec_end ? S_VEC : S_IDLE;
      end
      S_VEC: begin
        if (status_i.q_one || status_i.s_zero) begin
          cmd_o.op = pea_pkg::OP_ENT_SIMPLE;
          state_d  = S_VDONE;
        end else begin
          cmd_o.op = pea_pkg::OP_NORM_S;
          phase_d  = 1'b1;
          state_d  = S_NORM;
        end
      end
      S_DIVE: begin
        if (status_i.sign_ok) begin
          cmd_o.op = pea_pkg::OP_DIV_ENT;
          state_d  = S_DIVW;
        end else begin
          cmd_o.op = pea_pkg::OP_ENT_ZERO;
          state_d  = S_VDONE;
        end
      end
      S_DIVW: begin
        if (!status_i.div_busy) begin
          cmd_o.op = pea_pkg::OP_ENT_TAKE;
          state_d  = S_VDONE;
        end
      end
      S_VDONE: begin
        cmd_o.op = pea_pkg::OP_VEC_DONE;
        state_d  = status_i.band_end ? S_MSTART : S_IDLE;
      end
      S_MSTART: begin
        cmd_o.op = pea_pkg::OP_MEAN_START;
        state_d  = S_MWAIT;
      end
      S_MWAIT: begin
        if (!status_i.div_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = pea_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== dv/participation_entropy_accumulator_core_tb.sv =====
// ----------------------------------------------------------------------------
// participation_entropy_accumulator_core_tb
// Self-checking bench for the fixed-point participation entropy accumulator.
// A bit-exact predictor runs beside the core and forms each band mean when a
// request is taken. A monitor compares every band result against the oldest
// prediction. Directed tests cover edge cases, then random bands sweep the
// order q, with bursty requests and a stalling result sink.
// ----------------------------------------------------------------------------
module participation_entropy_accumulator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SETTLE_CYCLES = 200;   // worst case: two log2 loops plus divides
  localparam longint      CYCLE_LIMIT   = 3_000_000;
  localparam logic [15:0] Q_SHANNON     = 16'd4096;
  localparam logic [23:0] AMP_MAX_POS   = 24'h7F_FFFF;
  localparam logic [23:0] AMP_MAX_NEG   = 24'h80_0000;

  typedef struct {
    logic [pea_pkg::ENT_W-1:0]   entropy;
    logic [pea_pkg::TALLY_W-1:0] count;
    logic                        sat;
  } band_mean_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [pea_pkg::Q_W-1:0]     cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic signed [pea_pkg::AMP_W-1:0] amplitude_i = '0;
  logic                        vector_end_i = 1'b0;
  logic                        band_end_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [pea_pkg::ENT_W-1:0]   mean_entropy_o;
  logic [pea_pkg::TALLY_W-1:0] vectors_counted_o;
  logic                        saturated_o;

  participation_entropy_accumulator_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .amplitude_i(amplitude_i), .vector_end_i(vector_end_i), .band_end_i(band_end_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .mean_entropy_o(mean_entropy_o), .vectors_counted_o(vectors_counted_o),
    .saturated_o(saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the order register and the sums.
  // --------------------------------------------------------------------------
  logic [63:0]  root_rom [0:pea_pkg::LFRAC];
  logic [15:0]  q_order;
  logic [63:0]  power_acc;
  logic [63:0]  ent_acc;
  int unsigned  vec_count;
  bit           clip_flag;
  band_mean_t   band_means_q [$];

  int           requests_sent;
  int           bands_checked;
  int           errors;
  longint       cycle_count = 0;
  int           burst_left;

  // Integer square root, bit-serial.
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem, root, bitv;
    rem = x;
    root = '0;
    bitv = 64'h1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // log2 in Q.24, truncated; x must be nonzero.
  function automatic logic [63:0] log2_fix(input logic [63:0] x);
    int          msb;
    logic [63:0] v, frac;
    msb = 63;
    frac = '0;
    while (msb > 0 && !x[msb]) msb--;
    v = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
    for (int i = pea_pkg::LFRAC - 1; i >= 0; i--) begin
      v = (v * v) >> 30;
      if (v >= (64'h1 << 31)) begin
        v = v >> 1;
        frac[i] = 1'b1;
      end
    end
    return (64'(msb) << pea_pkg::LFRAC) | frac;
  endfunction

  // 2^-t with t in Q.24, result in Q0.32.
  function automatic logic [63:0] pow2_neg(input logic [63:0] t);
    logic [63:0] whole, r;
    whole = t >> pea_pkg::LFRAC;
    r = 64'h1 << 32;
    if (whole > 32) return '0;
    for (int k = 1; k <= pea_pkg::LFRAC; k++) begin
      if (t[pea_pkg::LFRAC-k]) r = (r * root_rom[k]) >> 32;
    end
    return r >> whole;
  endfunction

  function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] top);
    if (a > top || b > top - a) begin
      clip_flag = 1'b1;
      return top;
    end
    return a + b;
  endfunction

  function automatic logic [63:0] close_vector(input logic [15:0] qe);
    logic [63:0] ent, l, mag, lnm, den;
    bit          ln_pos, q_big;
    if (qe == Q_SHANNON) begin
      ent = power_acc >> 16;
    end else if (power_acc == 0) begin
      ent = (qe > Q_SHANNON) ? 64'h100_0000 : 64'h0;
    end else begin
      l = log2_fix(power_acc);
      ln_pos = l >= (64'd32 << pea_pkg::LFRAC);
      q_big = qe > Q_SHANNON;
      mag = ln_pos ? l - (64'd32 << pea_pkg::LFRAC) : (64'd32 << pea_pkg::LFRAC) - l;
      lnm = (mag * 64'(pea_pkg::LN2_Q32)) >> 32;
      den = q_big ? 64'(qe - Q_SHANNON) : 64'(Q_SHANNON - qe);
      // a vector that is not normalized yields a negative entropy: clamp to zero
      ent = (ln_pos != q_big) ? (lnm * 16) / den : 64'h0;
    end
    if (ent > 64'hFF_FFFF) begin
      ent = 64'hFF_FFFF;
      clip_flag = 1'b1;
    end
    return ent;
  endfunction

  // Advance the predictor by one request; queue a band mean on band end.
  function automatic void predict_band(input logic [23:0] amp, input bit vend, input bit bend);
    logic [15:0] qe;
    logic [63:0] mag, p, nl, term, ent, mean;
    band_mean_t  m;
    qe = (q_order == 0) ? 16'd1 : q_order;
    mag = amp[23] ? (64'h100_0000 - 64'(amp)) : 64'(amp);
    p = mag * mag;
    if (p != 0) begin
      nl = (64'(pea_pkg::P_FRAC) << pea_pkg::LFRAC) - log2_fix(p);
      if (qe == Q_SHANNON) begin
        term = ((p >> pea_pkg::PSHIFT) * ((nl * 64'(pea_pkg::LN2_Q32)) >> 32))
               >> pea_pkg::LFRAC;
      end else begin
        term = pow2_neg((nl * 64'(qe)) >> 12);
      end
      power_acc = clip_add(power_acc, term, (64'h1 << 48) - 1);
    end
    if (vend || bend) begin
      ent = close_vector(qe);
      if (vec_count < pea_pkg::MAX_VECTORS) begin
        vec_count++;
        ent_acc = clip_add(ent_acc, ent, (64'h1 << 40) - 1);
      end else begin
        clip_flag = 1'b1;
      end
      power_acc = '0;
    end
    if (bend) begin
      mean = (ent_acc + 64'(vec_count / 2)) / 64'(vec_count);
      if (mean > 64'hFF_FFFF) begin
        mean = 64'hFF_FFFF;
        clip_flag = 1'b1;
      end
      m.entropy = mean[23:0];
      m.count = vec_count[12:0];
      m.sat = clip_flag;
      band_means_q = {band_means_q, m};
      ent_acc = '0;
      vec_count = 0;
      clip_flag = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps between them.
  // Valid stays high across back-to-back requests inside a burst.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [23:0] amp, input bit vend, input bit bend);
    int gap;
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    amplitude_i <= amp;
    vector_end_i <= vend;
    band_end_i <= bend;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_band(amp, vend, bend);
    requests_sent++;
  endtask

  // Hold requests until every predicted band mean has been seen, then let
  // any trailing vector work settle.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (band_means_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_order(input logic [15:0] q);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= q;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    q_order = q;
  endtask

  // Amplitude scaled to roughly 1/sqrt(dim) so that vectors come out near
  // normalized; a random sign and full-range low bits.
  function automatic logic [23:0] near_unit_amp(input int dim);
    int unsigned span;
    logic [23:0] a;
    span = (dim <= 1) ? 24'h7F_FFFF : (24'h7F_FFFF >> ($clog2(dim) / 2 + (dim > 2 ? 1 : 0)));
    a = 24'($urandom_range(0, span));
    return $urandom_range(0, 1) ? (~a + 24'd1) : a;
  endfunction

  task automatic send_band(input int nvec, input int dim, input bit wild);
    logic [23:0] amp;
    for (int v = 0; v < nvec; v++) begin
      for (int c = 0; c < dim; c++) begin
        amp = wild ? 24'($urandom()) : near_unit_amp(dim);
        // occasionally end the band without marking the vector end
        if (v == nvec - 1 && c == dim - 1)
          send_request(amp, $urandom_range(0, 3) != 0, 1'b1);
        else
          send_request(amp, c == dim - 1, 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_amplitude_extremes();
    send_request(AMP_MAX_POS, 1'b1, 1'b0);
    send_request(AMP_MAX_NEG, 1'b1, 1'b0);
    send_request(24'h0, 1'b1, 1'b0);
    send_request(24'h1, 1'b0, 1'b0);
    send_request(24'hFF_FFFF, 1'b1, 1'b0);
    send_request(24'h5A_8279, 1'b0, 1'b0);
    send_request(24'hA5_7D87, 1'b0, 1'b1);   // band end without vector end
    send_request(24'h0, 1'b0, 1'b1);         // empty vector on its own band
  endtask

  task automatic test_order_corners();
    // zero order register acts as the smallest legal order
    set_order(16'd0);
    send_request(24'h40_0000, 1'b0, 1'b0);
    send_request(24'hC0_0000, 1'b1, 1'b1);
    // all-zero vector: zero entropy below q = 1, clipped maximum above
    set_order(16'd2048);
    send_request(24'h0, 1'b1, 1'b1);
    set_order(16'd8192);
    send_request(24'h0, 1'b1, 1'b1);
    // unnormalized vector gives a negative entropy
    send_request(AMP_MAX_POS, 1'b0, 1'b0);
    send_request(AMP_MAX_NEG, 1'b1, 1'b1);
    // order just above one drives the entropy out of range
    set_order(16'd4097);
    send_request(24'h08_0000, 1'b0, 1'b0);
    send_request(24'hF8_0000, 1'b1, 1'b1);
    set_order(16'hFFFF);
    send_request(24'h20_0000, 1'b0, 1'b0);
    send_request(24'h00_0001, 1'b1, 1'b1);
    set_order(16'd1);
    send_request(24'h00_0001, 1'b0, 1'b1);
  endtask

  task automatic test_random_bands();
    logic [15:0] orders [0:9];
    int          budget;
    orders = '{16'd4096, 16'd8192, 16'd2048, 16'd1, 16'hFFFF, 16'd4097, 16'd4095,
               16'd0, 16'($urandom()), 16'($urandom_range(4096, 12288))};
    foreach (orders[i]) begin
      set_order(orders[i]);
      budget = 125;
      while (budget > 0) begin
        int nvec, dim;
        nvec = $urandom_range(1, 5);
        dim = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        send_band(nvec, dim, $urandom_range(0, 5) == 0);
        budget -= nvec * dim;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: the ready pattern steps through always ready, coin toss,
  // mostly stalled and a periodic long stall.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    case (cycle_count[8:7])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= $urandom_range(0, 1);
      2'd2: out_ready_i <= ($urandom_range(0, 15) == 0);
      default: out_ready_i <= (cycle_count[4:0] > 5'd20);
    endcase
  end

  // Compare each accepted band result with the oldest prediction.
  always @(posedge clk_i) begin
    band_mean_t m;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (band_means_q.size() == 0) begin
        $display("%0t: unexpected band result entropy=%h count=%0d sat=%0b",
                 $time, mean_entropy_o, vectors_counted_o, saturated_o);
        errors++;
      end else begin
        m = band_means_q.pop_front();
        bands_checked++;
        if (mean_entropy_o !== m.entropy) begin
          $display("%0t: mean_entropy expected %h got %h", $time, m.entropy, mean_entropy_o);
          errors++;
        end
        if (vectors_counted_o !== m.count) begin
          $display("%0t: vectors_counted expected %0d got %0d",
                   $time, m.count, vectors_counted_o);
          errors++;
        end
        if (saturated_o !== m.sat) begin
          $display("%0t: saturated expected %0b got %0b", $time, m.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    requests_sent = 0;
    bands_checked = 0;
    burst_left = 0;
    root_rom[0] = 64'h8000_0000;
    for (int k = 1; k <= pea_pkg::LFRAC; k++) root_rom[k] = int_sqrt(root_rom[k-1] << 32);
    q_order = Q_SHANNON;
    power_acc = '0;
    ent_acc = '0;
    vec_count = 0;
    clip_flag = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_amplitude_extremes();
    test_order_corners();
    test_random_bands();

    drain_results();
    $display("Sent %0d component requests and checked %0d band means", requests_sent,
             bands_checked);
    $display("Orders swept: Shannon, zero, smallest, largest, near one, random");
    if (errors == 0 && band_means_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pea_pkg.sv
rtl/pea_div.sv
rtl/pea_datapath.sv
rtl/pea_ctrl.sv
rtl/participation_entropy_accumulator_core.sv
dv/participation_entropy_accumulator_core_tb.sv
